FILE: design/acd_pkg.sv
// Shared types, codes and a helper function for the angle conjugate doubling unit.
package acd_pkg;

	localparam int WORD           = 64;
	localparam int CNT_W          = 7;
	localparam int LAND_W         = 6;
	localparam int ANGLE_BITS_DEF = 64;

	typedef logic [WORD-1:0]   word_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [LAND_W-1:0] land_t;

	typedef struct packed {
		word_t numerator;
		word_t denominator;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		word_t      conjugate_numerator;
		word_t      normalized_denominator;
		cnt_t       preperiod;
		cnt_t       angle_period;
		land_t      landing_period;
	} out_t;

	// result status codes
	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_FAIL   = 2'd1;
	localparam logic [1:0] STS_PREPER = 2'd2;
	localparam logic [1:0] STS_LONG   = 2'd3;

	// datapath operations
	typedef logic [4:0] op_t;
	localparam op_t OP_NOP       = 5'd0;
	localparam op_t OP_LOAD      = 5'd1;
	localparam op_t OP_MOD       = 5'd2;
	localparam op_t OP_STRIP     = 5'd3;
	localparam op_t OP_KINIT     = 5'd4;
	localparam op_t OP_KSTEP     = 5'd5;
	localparam op_t OP_PINIT     = 5'd6;
	localparam op_t OP_PSTEP     = 5'd7;
	localparam op_t OP_GINIT_MB  = 5'd8;
	localparam op_t OP_GSTEP     = 5'd9;
	localparam op_t OP_TAKE_MG   = 5'd10;
	localparam op_t OP_MINIT     = 5'd11;
	localparam op_t OP_MSTEP     = 5'd12;
	localparam op_t OP_NORM      = 5'd13;
	localparam op_t OP_ULINIT    = 5'd14;
	localparam op_t OP_NPINIT    = 5'd15;
	localparam op_t OP_NPSTEP    = 5'd16;
	localparam op_t OP_ULSTEP    = 5'd17;
	localparam op_t OP_TAKE_CONJ = 5'd18;
	localparam op_t OP_LSTEP     = 5'd19;
	localparam op_t OP_GINIT_PI  = 5'd20;
	localparam op_t OP_LAND_P    = 5'd21;
	localparam op_t OP_LAND_G    = 5'd22;
	localparam op_t OP_RES       = 5'd23;

	// divider operand selection
	typedef logic [2:0] dsel_t;
	localparam dsel_t DS_NMOD = 3'd0;
	localparam dsel_t DS_MG   = 3'd1;
	localparam dsel_t DS_BG   = 3'd2;
	localparam dsel_t DS_NB   = 3'd3;
	localparam dsel_t DS_CONJ = 3'd4;

	// result kinds
	typedef logic [2:0] rkind_t;
	localparam rkind_t RK_FAIL  = 3'd0;
	localparam rkind_t RK_PRE   = 3'd1;
	localparam rkind_t RK_BIG   = 3'd2;
	localparam rkind_t RK_SMALL = 3'd3;
	localparam rkind_t RK_FULL  = 3'd4;

	typedef struct packed {
		op_t    op;
		logic   div_start;
		dsel_t  div_sel;
		rkind_t rkind;
	} cmd_t;

	typedef struct packed {
		logic d_zero;
		logic nd_even;
		logic b_even;
		logic k_fail;
		logic per_hit;
		logic p_last;
		logic g_done;
		logic div_done;
		logic m_done;
		logic k_nz;
		logic p_big;
		logic p_small;
		logic j_lt_p;
		logic i_last;
		logic land_hit;
	} stat_t;

	// 2n mod d, exact 64-bit behavior including wrap
	function automatic word_t dbl_mod(input word_t n, input word_t d);
		word_t r;
		r = d - n;
		return (n >= r) ? (n - r) : {n[WORD-2:0], 1'b0};
	endfunction

endpackage

FILE: design/angle_conjugate_doubling_unit.sv
// Angle conjugate doubling unit: top level joining controller and datapath.
//
// Input channel in_valid/in_ready carries one word: an angle numerator and
// denominator in turns. Output channel out_valid/out_ready carries one word
// per input: status, conjugate numerator, normalized denominator, preperiod,
// period and landing period.
// One angle is processed at a time; the work per word is data dependent. A
// zero denominator gives a fail result without any division; otherwise the
// word runs up to five divisions through the shared bit-serial divider,
// common-factor stripping, preperiod and period search, a binary gcd, a
// shift-add multiply, and for period p an unlinking walk of doubling steps
// followed by a landing search.
// in_ready is high only while the sequencer is idle.
// The result sits in an output register; a new word is accepted while it
// waits, and a finished result holds in the sequencer until the register
// is free, so a stalled receiver only stalls the next word.
// Reset (arst_n low) returns the sequencer to idle and drops out_valid.
module angle_conjugate_doubling_unit #(
	parameter int ANGLE_BITS = acd_pkg::ANGLE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  acd_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output acd_pkg::out_t  out_data
);
	acd_pkg::cmd_t  cmd;
	acd_pkg::stat_t stat;

	acd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	acd_dp #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_data (in_data),
		.stat    (stat),
		.res     (out_data)
	);
endmodule

FILE: design/acd_div.sv
// Radix-2 restoring divider: quotient and remainder, one bit per cycle.
module acd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  acd_pkg::word_t     dividend,
	input  acd_pkg::word_t     divisor,
	output logic               done,
	output acd_pkg::word_t     quotient,
	output acd_pkg::word_t     remainder
);
	localparam int W  = acd_pkg::WORD;
	localparam int CW = $clog2(W);

	acd_pkg::word_t quo_q, rem_q, dvs_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q, done_q;
	logic [W:0]     sh, diff;
	logic           ge;

	always_comb begin
		sh   = {rem_q, quo_q[W-1]};
		diff = sh - {1'b0, dvs_q};
		ge   = sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : sh[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

FILE: design/acd_dp.sv
// Datapath: working registers, doubling, gcd, multiply and result register.
module acd_dp #(
	parameter int ANGLE_BITS = acd_pkg::ANGLE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  acd_pkg::cmd_t   cmd,
	input  acd_pkg::in_t    in_data,
	output acd_pkg::stat_t  stat,
	output acd_pkg::out_t   res
);
	localparam int W   = acd_pkg::WORD;
	localparam int CNW = acd_pkg::CNT_W;
	localparam int CAP = ANGLE_BITS / 2;

	acd_pkg::word_t n_q, d_q, a_q, b_q, t_q, m_q;
	acd_pkg::word_t gx_q, gy_q, acc_q, ma_q, mb_q;
	acd_pkg::word_t na_q, nb_q, n1_q, d1_q, conj_q;
	acd_pkg::cnt_t  k_q, p_q, i_q, j_q, gc_q;
	acd_pkg::land_t land_q;
	acd_pkg::out_t  res_q;

	acd_pkg::word_t per_dbl, d_dbl, gres, mers, bhalf;
	acd_pkg::word_t na2, nb2, d1n, half, npv;
	acd_pkg::word_t div_a, div_b, div_quo, div_rem;
	logic           div_done;

	always_comb begin
		per_dbl = acd_pkg::dbl_mod(t_q, b_q);
		d_dbl   = acd_pkg::dbl_mod(t_q, d_q);
		gres    = (gx_q | gy_q) << gc_q;
		mers    = (p_q >= CNW'(W)) ? '1 : ((W'(1) << p_q) - W'(1));
		bhalf   = b_q >> 1;
		na2     = na_q << 1;
		nb2     = nb_q << 1;
		d1n     = d1_q << 1;
		half    = d1n >> 1;
		npv     = t_q << i_q;
		case (cmd.div_sel)
			acd_pkg::DS_NMOD: begin div_a = n_q;         div_b = d_q;     end
			acd_pkg::DS_MG:   begin div_a = m_q;         div_b = gres;    end
			acd_pkg::DS_BG:   begin div_a = b_q;         div_b = gres;    end
			acd_pkg::DS_NB:   begin div_a = n_q;         div_b = div_quo; end
			acd_pkg::DS_CONJ: begin div_a = n1_q - n_q;  div_b = d_q;     end
			default:          begin div_a = n_q;         div_b = d_q;     end
		endcase
	end

	acd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		case (cmd.op)
			acd_pkg::OP_LOAD: begin
				n_q <= in_data.numerator;
				d_q <= in_data.denominator;
			end
			acd_pkg::OP_MOD: n_q <= div_rem;
			acd_pkg::OP_STRIP: begin
				n_q <= n_q >> 1;
				d_q <= d_q >> 1;
			end
			acd_pkg::OP_KINIT: begin
				a_q <= n_q;
				b_q <= d_q;
				k_q <= '0;
			end
			acd_pkg::OP_KSTEP: begin
				k_q <= k_q + CNW'(1);
				b_q <= bhalf;
				a_q <= (a_q >= bhalf) ? (a_q - bhalf) : a_q;
			end
			acd_pkg::OP_PINIT: begin
				t_q <= a_q;
				p_q <= '0;
			end
			acd_pkg::OP_PSTEP: begin
				t_q <= per_dbl;
				p_q <= p_q + CNW'(1);
			end
			acd_pkg::OP_GINIT_MB: begin
				m_q  <= mers;
				gx_q <= mers;
				gy_q <= b_q;
				gc_q <= '0;
			end
			acd_pkg::OP_GINIT_PI: begin
				gx_q <= W'(p_q);
				gy_q <= W'(i_q);
				gc_q <= '0;
			end
			acd_pkg::OP_GSTEP: begin
				if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					gc_q <= gc_q + CNW'(1);
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else if (gx_q >= gy_q) begin
					gx_q <= gx_q - gy_q;
				end else begin
					gy_q <= gy_q - gx_q;
				end
			end
			acd_pkg::OP_TAKE_MG: a_q <= div_quo;
			acd_pkg::OP_MINIT: begin
				acc_q <= '0;
				ma_q  <= div_quo;
				mb_q  <= a_q;
			end
			acd_pkg::OP_MSTEP: begin
				if (mb_q[0]) acc_q <= acc_q + ma_q;
				ma_q <= ma_q << 1;
				mb_q <= mb_q >> 1;
			end
			acd_pkg::OP_NORM: begin
				n_q <= acc_q;
				d_q <= m_q << k_q;
			end
			acd_pkg::OP_ULINIT: begin
				d1_q <= d_q << 1;
				na_q <= n_q;
				nb_q <= n_q + d_q;
				n1_q <= n_q[0] ? n_q : (n_q + d_q);
				i_q  <= CNW'(2);
			end
			acd_pkg::OP_NPINIT: begin
				t_q <= n_q;
				j_q <= i_q;
			end
			acd_pkg::OP_NPSTEP: begin
				t_q <= d_dbl;
				j_q <= j_q + CNW'(1);
			end
			acd_pkg::OP_ULSTEP: begin
				d1_q <= d1n;
				na_q <= na2;
				nb_q <= nb2;
				i_q  <= i_q + CNW'(1);
				// move the preimage to the other half when it links the orbit
				if (na2 < npv && npv < nb2) begin
					if (n1_q < na2 || nb2 < n1_q) n1_q <= n1_q + half;
				end else begin
					if (na2 < n1_q && n1_q < nb2) n1_q <= n1_q + half;
				end
			end
			acd_pkg::OP_TAKE_CONJ: begin
				conj_q <= div_quo;
				t_q    <= div_quo;
				i_q    <= CNW'(1);
			end
			acd_pkg::OP_LSTEP: begin
				t_q <= d_dbl;
				i_q <= i_q + CNW'(1);
			end
			acd_pkg::OP_LAND_P: land_q <= p_q[acd_pkg::LAND_W-1:0];
			acd_pkg::OP_LAND_G: land_q <= gres[acd_pkg::LAND_W-1:0];
			acd_pkg::OP_RES: begin
				res_q <= '0;
				case (cmd.rkind)
					acd_pkg::RK_PRE, acd_pkg::RK_BIG: begin
						res_q.status <= (cmd.rkind == acd_pkg::RK_PRE) ?
							acd_pkg::STS_PREPER : acd_pkg::STS_LONG;
						res_q.normalized_denominator <= d_q;
						res_q.preperiod              <= k_q;
						res_q.angle_period           <= p_q;
					end
					acd_pkg::RK_SMALL: begin
						res_q.status                 <= acd_pkg::STS_OK;
						res_q.conjugate_numerator    <=
							(p_q == CNW'(2)) ? (W'(3) - n_q) : n_q;
						res_q.normalized_denominator <= d_q;
						res_q.preperiod              <= k_q;
						res_q.angle_period           <= p_q;
						res_q.landing_period         <= acd_pkg::LAND_W'(1);
					end
					acd_pkg::RK_FULL: begin
						res_q.status                 <= acd_pkg::STS_OK;
						res_q.conjugate_numerator    <= conj_q;
						res_q.normalized_denominator <= d_q;
						res_q.preperiod              <= k_q;
						res_q.angle_period           <= p_q;
						res_q.landing_period         <= land_q;
					end
					default: res_q.status <= acd_pkg::STS_FAIL;
				endcase
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.d_zero   = (d_q == '0);
		stat.nd_even  = !n_q[0] && !d_q[0];
		stat.b_even   = !b_q[0];
		stat.k_fail   = (k_q >= CNW'(ANGLE_BITS));
		stat.per_hit  = (per_dbl == a_q);
		stat.p_last   = ((p_q + CNW'(1)) == (CNW'(ANGLE_BITS) - k_q));
		stat.g_done   = (gx_q == '0) || (gy_q == '0);
		stat.div_done = div_done;
		stat.m_done   = (mb_q == '0);
		stat.k_nz     = (k_q != '0);
		stat.p_big    = (p_q > CNW'(CAP));
		stat.p_small  = (p_q <= CNW'(2));
		stat.j_lt_p   = (j_q < p_q);
		stat.i_last   = (i_q == p_q);
		stat.land_hit = (d_dbl == n_q);
	end

	assign res = res_q;
endmodule

FILE: design/acd_ctrl.sv
// Controller: sequences the datapath through reduction, period search and conjugate steps.
module acd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  acd_pkg::stat_t  stat,
	output acd_pkg::cmd_t   cmd
);
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_CHK   = 5'd1;
	localparam logic [4:0] S_MOD   = 5'd2;
	localparam logic [4:0] S_STRIP = 5'd3;
	localparam logic [4:0] S_KLOOP = 5'd4;
	localparam logic [4:0] S_PER   = 5'd5;
	localparam logic [4:0] S_MERS  = 5'd6;
	localparam logic [4:0] S_GCD   = 5'd7;
	localparam logic [4:0] S_DMG   = 5'd8;
	localparam logic [4:0] S_DBG   = 5'd9;
	localparam logic [4:0] S_DNB   = 5'd10;
	localparam logic [4:0] S_MUL   = 5'd11;
	localparam logic [4:0] S_DEC   = 5'd12;
	localparam logic [4:0] S_UNP   = 5'd13;
	localparam logic [4:0] S_UIN   = 5'd14;
	localparam logic [4:0] S_CDIV  = 5'd15;
	localparam logic [4:0] S_CWAIT = 5'd16;
	localparam logic [4:0] S_LAND  = 5'd17;
	localparam logic [4:0] S_LGCD  = 5'd18;
	localparam logic [4:0] S_EMIT  = 5'd19;

	logic [4:0]       state_q, state_d;
	acd_pkg::rkind_t  rk_q, rk_d;
	logic             out_valid_q, out_valid_d;

	always_comb begin
		state_d     = state_q;
		rk_d        = rk_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd         = '0;
		cmd.op      = acd_pkg::OP_NOP;
		cmd.div_sel = acd_pkg::DS_NMOD;
		cmd.rkind   = rk_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = acd_pkg::OP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.d_zero) begin
					rk_d    = acd_pkg::RK_FAIL;
					state_d = S_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = acd_pkg::DS_NMOD;
					state_d       = S_MOD;
				end
			end
			S_MOD: begin
				if (stat.div_done) begin
					cmd.op  = acd_pkg::OP_MOD;
					state_d = S_STRIP;
				end
			end
			S_STRIP: begin
				if (stat.nd_even) begin
					cmd.op = acd_pkg::OP_STRIP;
				end else begin
					cmd.op  = acd_pkg::OP_KINIT;
					state_d = S_KLOOP;
				end
			end
			S_KLOOP: begin
				if (stat.b_even) begin
					cmd.op = acd_pkg::OP_KSTEP;
				end else if (stat.k_fail) begin
					rk_d    = acd_pkg::RK_FAIL;
					state_d = S_EMIT;
				end else begin
					cmd.op  = acd_pkg::OP_PINIT;
					state_d = S_PER;
				end
			end
			S_PER: begin
				cmd.op = acd_pkg::OP_PSTEP;
				if (stat.per_hit) begin
					state_d = S_MERS;
				end else if (stat.p_last) begin
					rk_d    = acd_pkg::RK_FAIL;
					state_d = S_EMIT;
				end
			end
			S_MERS: begin
				cmd.op  = acd_pkg::OP_GINIT_MB;
				state_d = S_GCD;
			end
			S_GCD: begin
				if (stat.g_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = acd_pkg::DS_MG;
					state_d       = S_DMG;
				end else begin
					cmd.op = acd_pkg::OP_GSTEP;
				end
			end
			S_DMG: begin
				if (stat.div_done) begin
					cmd.op        = acd_pkg::OP_TAKE_MG;
					cmd.div_start = 1'b1;
					cmd.div_sel   = acd_pkg::DS_BG;
					state_d       = S_DBG;
				end
			end
			S_DBG: begin
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = acd_pkg::DS_NB;
					state_d       = S_DNB;
				end
			end
			S_DNB: begin
				if (stat.div_done) begin
					cmd.op  = acd_pkg::OP_MINIT;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (stat.m_done) begin
					cmd.op  = acd_pkg::OP_NORM;
					state_d = S_DEC;
				end else begin
					cmd.op = acd_pkg::OP_MSTEP;
				end
			end
			S_DEC: begin
				if (stat.k_nz) begin
					rk_d    = acd_pkg::RK_PRE;
					state_d = S_EMIT;
				end else if (stat.p_big) begin
					rk_d    = acd_pkg::RK_BIG;
					state_d = S_EMIT;
				end else if (stat.p_small) begin
					rk_d    = acd_pkg::RK_SMALL;
					state_d = S_EMIT;
				end else begin
					cmd.op  = acd_pkg::OP_ULINIT;
					state_d = S_UNP;
				end
			end
			S_UNP: begin
				cmd.op  = acd_pkg::OP_NPINIT;
				state_d = S_UIN;
			end
			S_UIN: begin
				if (stat.j_lt_p) begin
					cmd.op = acd_pkg::OP_NPSTEP;
				end else begin
					cmd.op  = acd_pkg::OP_ULSTEP;
					state_d = stat.i_last ? S_CDIV : S_UNP;
				end
			end
			S_CDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = acd_pkg::DS_CONJ;
				state_d       = S_CWAIT;
			end
			S_CWAIT: begin
				if (stat.div_done) begin
					cmd.op  = acd_pkg::OP_TAKE_CONJ;
					state_d = S_LAND;
				end
			end
			S_LAND: begin
				if (stat.land_hit && !stat.i_last) begin
					cmd.op  = acd_pkg::OP_GINIT_PI;
					state_d = S_LGCD;
				end else if (stat.land_hit || stat.i_last) begin
					cmd.op  = acd_pkg::OP_LAND_P;
					rk_d    = acd_pkg::RK_FULL;
					state_d = S_EMIT;
				end else begin
					cmd.op = acd_pkg::OP_LSTEP;
				end
			end
			S_LGCD: begin
				if (stat.g_done) begin
					cmd.op  = acd_pkg::OP_LAND_G;
					rk_d    = acd_pkg::RK_FULL;
					state_d = S_EMIT;
				end else begin
					cmd.op = acd_pkg::OP_GSTEP;
				end
			end
			S_EMIT: begin
				// hold until the output word slot is free
				if (!out_valid_q || out_ready) begin
					cmd.op      = acd_pkg::OP_RES;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rk_q        <= acd_pkg::RK_FAIL;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rk_q        <= rk_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
endmodule
